### sv/partitioned_multi_queue_top_macros.svh
// Assertion macros for the partitioned multi-queue checker.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef PARTITIONED_MULTI_QUEUE_TOP_MACROS_SVH
`define PARTITIONED_MULTI_QUEUE_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define PMQ_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PMQ_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pmq_pkg.sv
// Shared types and constants for the partitioned multi-queue block.
// No dependencies; used by the top level and its checker.
package pmq_pkg;

    localparam int DATA_W   = 32;
    localparam int QIDX_W   = 3;
    localparam int NQ_W     = 4;
    localparam int SLOT_W   = 9;
    localparam int CFG_IDX_W = 1;
    localparam int ADDR_SUM_W = QIDX_W + SLOT_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_QUEUES  = 1'b0,
        CFG_TOTAL_SLOTS = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode                  opcode;
        logic [QIDX_W-1:0]        queue_index;
        logic signed [DATA_W-1:0] write_value;
    } t_in_word;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] read_value;
    } t_out_word;

endpackage

### sv/partitioned_multi_queue_top.sv
// Several circular FIFO queues carved out of one shared word store.
// Depends on pmq_pkg.
//
// Each accepted word is a push or a pop on one queue and gives exactly one result word,
// held in the input register, then the result register once the output is free. One word
// can enter every cycle unless a configuration write or divide is busy or the output
// stalls: pointer and count updates for a queue finish in the cycle the word leaves the
// input register and the store is read into the result register. The partition size
// (total_slots / num_queues) is formed by a bit-serial divider after each configuration
// write; every write empties all queues but keeps store contents. The reset partition
// size is ready at once. A bad queue index reports status 3 and changes nothing.
module partitioned_multi_queue_top #(
    parameter int MAX_QUEUES  = 8,
    parameter int STORE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pmq_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pmq_pkg::SLOT_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pmq_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pmq_pkg::t_out_word                  o_out_word
);

    localparam int QI_W = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int SA_W = $clog2(STORE_DEPTH);
    localparam int RST_NQ    = (MAX_QUEUES < 8) ? MAX_QUEUES : 8;
    localparam int RST_SLOTS = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;
    localparam int RST_PART  = RST_SLOTS / RST_NQ;
    localparam int DIV_CNT_W = $clog2(pmq_pkg::SLOT_W + 2);

    logic [pmq_pkg::NQ_W-1:0]   r_num_queues;
    logic [pmq_pkg::SLOT_W-1:0] r_total_slots;
    logic [pmq_pkg::NQ_W-1:0]   w_eff_nq;
    logic [pmq_pkg::SLOT_W-1:0] w_eff_slots;

    logic [DIV_CNT_W-1:0]       r_div_cnt;
    logic [pmq_pkg::NQ_W-1:0]   r_div_rem;
    logic [pmq_pkg::NQ_W-1:0]   r_div_den;
    logic [pmq_pkg::SLOT_W-1:0] r_div_quo;
    logic [pmq_pkg::NQ_W:0]     w_rem_sh;
    logic                       w_div_busy;

    logic [pmq_pkg::SLOT_W-1:0] r_head [MAX_QUEUES];
    logic [pmq_pkg::SLOT_W-1:0] r_tail [MAX_QUEUES];
    logic [pmq_pkg::SLOT_W-1:0] r_cnt  [MAX_QUEUES];
    logic signed [pmq_pkg::DATA_W-1:0] r_mem [STORE_DEPTH];

    logic                       r_s1_valid;
    pmq_pkg::t_in_word          r_s1;
    logic                       r_out_valid;
    pmq_pkg::t_status           r_out_status;
    logic                       r_out_pop;
    logic signed [pmq_pkg::DATA_W-1:0] r_rd_data;

    logic                       w_adv;
    logic                       w_accept;
    logic [QI_W-1:0]            w_qi;
    logic                       w_bad;
    logic [pmq_pkg::SLOT_W-1:0] w_cnt;
    logic [pmq_pkg::SLOT_W-1:0] w_off;
    logic [pmq_pkg::SLOT_W:0]   w_off_inc;
    logic [pmq_pkg::SLOT_W-1:0] w_off_nxt;
    logic [pmq_pkg::ADDR_SUM_W-1:0] w_addr_sum;
    logic [SA_W-1:0]            w_addr;
    pmq_pkg::t_status           w_status;
    logic                       w_push_ok;
    logic                       w_pop_ok;

    assign w_eff_nq = (int'(r_num_queues) > MAX_QUEUES) ? pmq_pkg::NQ_W'(MAX_QUEUES)
                                                        : r_num_queues;
    assign w_eff_slots = (int'(r_total_slots) > STORE_DEPTH) ? pmq_pkg::SLOT_W'(STORE_DEPTH)
                                                             : r_total_slots;

    // partition size divider: one quotient bit per cycle
    assign w_div_busy = (r_div_cnt != '0);
    assign w_rem_sh   = {r_div_rem, r_div_quo[pmq_pkg::SLOT_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_queues  <= pmq_pkg::NQ_W'(8);
            r_total_slots <= pmq_pkg::SLOT_W'(256);
            r_div_cnt     <= '0;
            r_div_quo     <= pmq_pkg::SLOT_W'(RST_PART);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pmq_pkg::CFG_NUM_QUEUES) begin
                r_num_queues <= i_cfg_data[pmq_pkg::NQ_W-1:0];
            end else begin
                r_total_slots <= i_cfg_data;
            end
            r_div_cnt <= DIV_CNT_W'(pmq_pkg::SLOT_W + 1);
        end else if (r_div_cnt == DIV_CNT_W'(pmq_pkg::SLOT_W + 1)) begin
            r_div_rem <= '0;
            r_div_den <= w_eff_nq;
            r_div_quo <= w_eff_slots;
            r_div_cnt <= r_div_cnt - 1'b1;
        end else if (w_div_busy) begin
            if (w_rem_sh >= {1'b0, r_div_den}) begin
                r_div_rem <= pmq_pkg::NQ_W'(w_rem_sh - {1'b0, r_div_den});
                r_div_quo <= {r_div_quo[pmq_pkg::SLOT_W-2:0], 1'b1};
            end else begin
                r_div_rem <= w_rem_sh[pmq_pkg::NQ_W-1:0];
                r_div_quo <= {r_div_quo[pmq_pkg::SLOT_W-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    assign w_adv      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !w_div_busy && !i_cfg_we && (!r_s1_valid || w_adv);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_qi  = QI_W'(r_s1.queue_index);
        w_bad = (w_eff_nq == '0) || ({1'b0, r_s1.queue_index} >= w_eff_nq);
        w_cnt = r_cnt[w_qi];
        w_off = (r_s1.opcode == pmq_pkg::OP_PUSH) ? r_tail[w_qi] : r_head[w_qi];
        w_off_inc = {1'b0, w_off} + 1'b1;
        w_off_nxt = (w_off_inc >= {1'b0, r_div_quo}) ? '0 : w_off_inc[pmq_pkg::SLOT_W-1:0];
        w_addr_sum = pmq_pkg::ADDR_SUM_W'(r_s1.queue_index) * pmq_pkg::ADDR_SUM_W'(r_div_quo)
                   + pmq_pkg::ADDR_SUM_W'(w_off);
        w_addr = SA_W'(w_addr_sum);
        if (w_bad) begin
            w_status = pmq_pkg::ST_BADIDX;
        end else if (r_s1.opcode == pmq_pkg::OP_PUSH) begin
            w_status = (w_cnt >= r_div_quo) ? pmq_pkg::ST_FULL : pmq_pkg::ST_OK;
        end else begin
            w_status = (w_cnt == '0) ? pmq_pkg::ST_EMPTY : pmq_pkg::ST_OK;
        end
        w_push_ok = w_adv && (w_status == pmq_pkg::ST_OK) && (r_s1.opcode == pmq_pkg::OP_PUSH);
        w_pop_ok  = w_adv && (w_status == pmq_pkg::ST_OK) && (r_s1.opcode == pmq_pkg::OP_POP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            for (int i = 0; i < MAX_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else if (w_push_ok) begin
            r_tail[w_qi] <= w_off_nxt;
            r_cnt[w_qi]  <= w_cnt + 1'b1;
        end else if (w_pop_ok) begin
            r_cnt[w_qi] <= w_cnt - 1'b1;
            if (w_cnt == pmq_pkg::SLOT_W'(1)) begin
                r_head[w_qi] <= '0;
                r_tail[w_qi] <= '0;
            end else begin
                r_head[w_qi] <= w_off_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[w_addr] <= r_s1.write_value;
        end
        if (w_pop_ok) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= i_in_word;
        end
        if (w_adv) begin
            r_out_status <= w_status;
            r_out_pop    <= (w_status == pmq_pkg::ST_OK) && (r_s1.opcode == pmq_pkg::OP_POP);
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out_word.status     = r_out_status;
        o_out_word.read_value = r_out_pop ? r_rd_data : '0;
    end

endmodule

### sv/pmq_checker.sv
// Port-level checks for the partitioned multi-queue top level, bound to it below.
// Depends on pmq_pkg and partitioned_multi_queue_top_macros.svh.
`include "partitioned_multi_queue_top_macros.svh"

module pmq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input pmq_pkg::t_out_word            o_out_word
);

    logic w_in_seen;
    logic w_in_free;
    logic w_out_stall;
    logic w_fail;

    assign w_in_seen   = i_in_valid && o_in_ready;
    assign w_in_free   = w_in_seen && !o_out_valid && i_rst_n;
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_fail      = o_out_valid && (o_out_word.status != pmq_pkg::ST_OK);

    `PMQ_AST_NXT(a_out_hold, w_out_stall, o_out_valid && $stable(o_out_word), "result changed")

    `PMQ_AST_NXT(a_cfg_holdoff, i_cfg_we, !o_in_ready, "input taken while partition size forms")

    `PMQ_AST_IMP(a_zero_on_fail, w_fail, o_out_word.read_value == '0, "nonzero value on failure")

    `PMQ_AST_IMP(a_result_due, $past(w_in_free, 2) && $past(i_rst_n), o_out_valid, "result word late")

endmodule

bind partitioned_multi_queue_top pmq_checker u_pmq_checker (.*);
